FILE: src/msdw_pkg.sv
package msdw_pkg;

  localparam int VALUE_BITS   = 10;
  localparam int WINDOW_DEPTH = 1024;

  localparam int VALUE_W   = 10;
  localparam int BEST_W    = 19;
  localparam int MAP_DEPTH = 1 << VALUE_BITS;
  localparam int IDX_BITS  = $clog2(WINDOW_DEPTH);
  localparam int OCC_BITS  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS  = VALUE_BITS + OCC_BITS;
  localparam int WIDE_BITS = (SUM_BITS > BEST_W) ? SUM_BITS : BEST_W;
  localparam longint SUM_MAX = (64'd1 << BEST_W) - 64'd1;

  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [VALUE_BITS-1:0] v;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_PUSH,
    ST_DSTART,
    ST_POP
  } state_t;

  typedef enum logic [1:0] {
    POP_MATCH,
    POP_ONE,
    POP_DRAIN
  } pop_mode_t;

  function automatic logic [IDX_BITS-1:0] next_slot(input logic [IDX_BITS-1:0] i);
    return (i == IDX_BITS'(WINDOW_DEPTH - 1)) ? '0 : IDX_BITS'(i + 1'b1);
  endfunction

endpackage

FILE: src/msdw_in_if.sv
interface msdw_in_if;
  import msdw_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

FILE: src/msdw_out_if.sv
interface msdw_out_if;
  import msdw_pkg::*;

  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_sum;

  modport source (output valid, output best_sum, input ready);
  modport sink (input valid, input best_sum, output ready);
endinterface

FILE: src/msdw_ram.sv
module msdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/msdw_front.sv
module msdw_front (
  input  logic                  clk,
  input  logic                  rst,
  msdw_in_if.sink               feed,
  input  logic                  clearing,
  input  logic                  take,
  output msdw_pkg::queue_head_t q
);
  import msdw_pkg::*;

  item_t                entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] cnt;
  logic                 push;
  logic                 pop;

  assign feed.ready = (cnt != QCNT_BITS'(QDEPTH)) && !clearing;
  assign push       = feed.valid && feed.ready;
  assign pop        = take && (cnt != '0);
  assign q.valid    = (cnt != '0);
  assign q.item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].v    <= VALUE_BITS'(feed.value);
      entries[wr_ptr].last <= feed.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : QPTR_BITS'(rd_ptr + 1'b1);
      end
      cnt <= QCNT_BITS'(cnt + QCNT_BITS'(push) - QCNT_BITS'(pop));
    end
  end

endmodule

FILE: src/msdw_back.sv
module msdw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  msdw_pkg::queue_head_t q,
  output logic                  take,
  output logic                  clearing,
  msdw_out_if.source            result
);
  import msdw_pkg::*;

  state_t                state;
  state_t                state_next;
  pop_mode_t             mode;
  pop_mode_t             mode_next;
  logic [VALUE_BITS-1:0] cur_v;
  logic                  cur_last;
  logic [IDX_BITS-1:0]   head;
  logic [IDX_BITS-1:0]   tail;
  logic [OCC_BITS-1:0]   occ;
  logic [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-1:0]   best;
  logic [VALUE_BITS-1:0] clr_cnt;
  logic                  out_valid;
  logic [BEST_W-1:0]     out_best;

  logic                  pres_rd;
  logic                  pres_we;
  logic [VALUE_BITS-1:0] pres_waddr;
  logic                  pres_wdata;
  logic [VALUE_BITS-1:0] u;
  logic [IDX_BITS-1:0]   st_raddr;

  logic                  out_free;
  logic                  full;
  logic                  push_now;
  logic                  pop_done;
  logic [SUM_BITS-1:0]   sum_inc;
  logic [SUM_BITS-1:0]   best_new;
  logic [WIDE_BITS-1:0]  best_wide;

  msdw_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_present (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (pres_wdata),
    .raddr (q.item.v),
    .rdata (pres_rd)
  );

  msdw_ram #(.WIDTH(VALUE_BITS), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk   (clk),
    .we    (push_now),
    .waddr (tail),
    .wdata (cur_v),
    .raddr (st_raddr),
    .rdata (u)
  );

  assign out_free  = !out_valid || result.ready;
  assign full      = (occ == OCC_BITS'(WINDOW_DEPTH));
  assign sum_inc   = SUM_BITS'(sum + SUM_BITS'(cur_v));
  assign best_new  = (sum_inc > best) ? sum_inc : best;
  assign best_wide = WIDE_BITS'(best_new);
  assign clearing  = (state == ST_CLEAR);

  always_comb begin
    unique case (mode)
      POP_MATCH: pop_done = (u == cur_v) || (occ == OCC_BITS'(1));
      POP_ONE:   pop_done = 1'b1;
      POP_DRAIN: pop_done = (occ == OCC_BITS'(1));
      default:   pop_done = 1'b1;
    endcase
  end

  always_comb begin
    take       = 1'b0;
    push_now   = 1'b0;
    pres_we    = 1'b0;
    pres_waddr = cur_v;
    pres_wdata = 1'b0;
    st_raddr   = head;
    unique case (state)
      ST_CLEAR: begin
        pres_we    = 1'b1;
        pres_waddr = clr_cnt;
      end
      ST_IDLE: begin
        take = q.valid;
      end
      ST_CHECK: begin
        push_now = !pres_rd && !full && (!cur_last || out_free);
      end
      ST_PUSH: begin
        push_now = !cur_last || out_free;
      end
      ST_DSTART: begin
      end
      ST_POP: begin
        pres_we    = 1'b1;
        pres_waddr = u;
        st_raddr   = next_slot(head);
      end
      default: begin
      end
    endcase
    if (push_now) begin
      pres_we    = 1'b1;
      pres_waddr = cur_v;
      pres_wdata = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    mode_next  = mode;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == VALUE_BITS'(MAP_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q.valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (pres_rd) begin
          state_next = ST_POP;
          mode_next  = POP_MATCH;
        end else if (full) begin
          state_next = ST_POP;
          mode_next  = POP_ONE;
        end else if (push_now) begin
          state_next = cur_last ? ST_DSTART : ST_IDLE;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_now) begin
          state_next = cur_last ? ST_DSTART : ST_IDLE;
        end
      end
      ST_DSTART: begin
        state_next = ST_POP;
        mode_next  = POP_DRAIN;
      end
      ST_POP: begin
        if (pop_done) begin
          state_next = (mode == POP_DRAIN) ? ST_IDLE : ST_PUSH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_v    <= q.item.v;
      cur_last <= q.item.last;
    end
    if (push_now && cur_last) begin
      out_best <= (best_wide > WIDE_BITS'(SUM_MAX)) ? BEST_W'(SUM_MAX) : BEST_W'(best_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      mode      <= POP_MATCH;
      clr_cnt   <= '0;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      sum       <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= VALUE_BITS'(clr_cnt + 1'b1);
      end
      if (push_now && cur_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_POP) begin
        head <= next_slot(head);
        occ  <= OCC_BITS'(occ - 1'b1);
        sum  <= SUM_BITS'(sum - SUM_BITS'(u));
      end
      if (push_now) begin
        tail <= next_slot(tail);
        occ  <= OCC_BITS'(occ + 1'b1);
        sum  <= sum_inc;
        if (cur_last) begin
          best <= '0;
        end else begin
          best <= best_new;
        end
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.best_sum = out_best;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_BITS'(WINDOW_DEPTH))
    else $error("window occupancy beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> (occ != '0))
    else $error("eviction from empty window");

  a_drain_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP && mode == POP_DRAIN && pop_done) |=> (occ == '0 && sum == '0))
    else $error("window not empty after drain");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (push_now && cur_last) |-> out_free)
    else $error("result register overwritten");

endmodule

FILE: src/max_sum_distinct_window.sv
// Each item takes a presence lookup, then a check and append, if nothing is evicted;
// otherwise front elements are evicted after the check (a full window forces one), the append coming last.
// After a last item, every element left in the window is drained to clear the map.
// best_sum is valid the cycle after the last item is appended; a 2-entry queue takes input ahead.
// Reset is synchronous; it is followed by a sweep over all 2^VALUE_BITS entries of the presence
// map, during which no input transfer is taken.
module max_sum_distinct_window (
  input  logic       clk,
  input  logic       rst,
  msdw_in_if.sink    feed,
  msdw_out_if.source result
);
  import msdw_pkg::*;

  queue_head_t q;
  logic        take;
  logic        clearing;

  msdw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .feed     (feed),
    .clearing (clearing),
    .take     (take),
    .q        (q)
  );

  msdw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q        (q),
    .take     (take),
    .clearing (clearing),
    .result   (result)
  );

endmodule

FILE: verif/msdw_checker.sv
`timescale 1ns / 100ps

module msdw_checker
  import msdw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  msdw_in_if   feed,
  msdw_out_if  result,
  output int   mismatches,
  output int   awaiting
);

  logic                  in_window [MAP_DEPTH];
  logic [VALUE_BITS-1:0] window_q [$];
  longint                run_sum;
  longint                peak_sum;
  logic [BEST_W-1:0]     expected_best [$];
  int                    err_cnt;

  function automatic void clear_window();
    foreach (in_window[i]) in_window[i] = 1'b0;
    window_q.delete();
    run_sum  = 0;
    peak_sum = 0;
  endfunction

  function automatic logic [VALUE_BITS-1:0] evict_front();
    logic [VALUE_BITS-1:0] gone;
    gone = window_q.pop_front();
    in_window[gone] = 1'b0;
    run_sum -= longint'(gone);
    return gone;
  endfunction

  // Slide the distinct-value window over one element and queue the peak sum on last.
  function automatic void slide_window(input logic [VALUE_W-1:0] raw, input logic is_last);
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] gone;
    v = raw[VALUE_BITS-1:0];
    if (in_window[v]) begin
      do begin
        gone = evict_front();
      end while (gone != v && window_q.size() > 0);
    end
    if (window_q.size() >= WINDOW_DEPTH) begin
      gone = evict_front();
    end
    window_q.push_back(v);
    in_window[v] = 1'b1;
    run_sum += longint'(v);
    if (run_sum > peak_sum) begin
      peak_sum = run_sum;
    end
    if (is_last) begin
      expected_best.push_back(BEST_W'((peak_sum > SUM_MAX) ? SUM_MAX : peak_sum));
      clear_window();
    end
  endfunction

  initial begin
    clear_window();
    err_cnt = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_window();
      expected_best.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_best.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: unexpected result transfer best_sum=%0d", $realtime, result.best_sum);
          end
        end else begin
          logic [BEST_W-1:0] want;
          want = expected_best.pop_front();
          if (result.best_sum !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: best_sum mismatch: expected %0d, got %0d",
                       $realtime, want, result.best_sum);
            end
          end
        end
      end
      if (feed.valid && feed.ready) begin
        slide_window(feed.value, feed.last);
      end
    end
    mismatches <= err_cnt;
    awaiting   <= expected_best.size();
  end

endmodule

FILE: verif/tb_max_sum_distinct_window.sv
`timescale 1ns / 100ps

module tb_max_sum_distinct_window;
  import msdw_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 140;

  logic clk;
  logic rst;

  msdw_in_if  feed_if ();
  msdw_out_if result_if ();

  int mismatches;
  int awaiting;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_asked;
  int hold_granted;
  int hold_left;
  int quiet_cycles;
  int sent_items;

  max_sum_distinct_window i_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_if),
    .result (result_if)
  );

  msdw_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed_if),
    .result     (result_if),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    feed_if.valid   = 1'b0;
    feed_if.value   = '0;
    feed_if.last    = 1'b0;
    result_if.ready = 1'b0;
    hold_asked      = 0;
    hold_granted    = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_granted != hold_asked) begin
      result_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_granted <= hold_granted + 1;
    end else begin
      result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [VALUE_W-1:0] v, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      feed_if.valid <= 1'b0;
      @(posedge clk);
    end
    feed_if.valid <= 1'b1;
    feed_if.value <= v;
    feed_if.last  <= is_last;
    do @(posedge clk); while (!feed_if.ready);
    sent_items++;
  endtask

  task automatic wait_results_drained();
    feed_if.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic send_random_sequence(input int len);
    int span;
    int base;
    case ($urandom_range(3))
      0:       span = $urandom_range(1, 8);
      1:       span = $urandom_range(9, 64);
      default: span = MAP_DEPTH;
    endcase
    base = $urandom_range(0, MAP_DEPTH - span);
    for (int k = 0; k < len; k++) begin
      send_item(VALUE_W'(base + $urandom_range(0, span - 1)), k == len - 1);
    end
  endtask

  // every value once in shuffled order fills the window, then a few repeats
  task automatic send_full_window_sequence();
    int perm [MAP_DEPTH];
    int j;
    int tmp;
    foreach (perm[i]) perm[i] = i;
    for (int i = MAP_DEPTH - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    foreach (perm[i]) send_item(VALUE_W'(perm[i]), 1'b0);
    for (int k = 0; k < 6; k++) begin
      send_item(VALUE_W'($urandom_range(0, MAP_DEPTH - 1)), k == 5);
    end
  endtask

  task automatic run_random_phase();
    int target;
    target = sent_items + PHASE_ITEMS;
    while (sent_items < target) begin
      if ($urandom_range(9) == 0) begin
        send_random_sequence($urandom_range(31, 150));
      end else begin
        send_random_sequence($urandom_range(1, 30));
      end
    end
  endtask

  initial begin
    sent_items = 0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 17;
    rx_idle_pct = 84;

    // directed
    send_item(10'd0, 1'b1);
    send_item(10'd1023, 1'b1);
    send_item(10'd1023, 1'b0);
    send_item(10'd1023, 1'b0);
    send_item(10'd1023, 1'b1);
    send_item(10'd5, 1'b0);
    send_item(10'd3, 1'b0);
    send_item(10'd5, 1'b0);
    send_item(10'd7, 1'b1);
    send_item(10'd682, 1'b0);
    send_item(10'd341, 1'b1);
    send_item(10'd0, 1'b0);
    send_item(10'd0, 1'b0);
    send_item(10'd0, 1'b1);
    send_item(10'd1, 1'b0);
    send_item(10'd2, 1'b0);
    send_item(10'd3, 1'b0);
    send_item(10'd1, 1'b0);
    send_item(10'd1000, 1'b0);
    send_item(10'd2, 1'b1);
    wait_results_drained();

    run_random_phase();
    wait_results_drained();

    tx_idle_pct = 84;
    rx_idle_pct = 17;
    run_random_phase();
    wait_results_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // long receiver hold-off with short sequences so the block backs up
    hold_asked <= hold_asked + 1;
    for (int k = 0; k < 40; k++) begin
      send_random_sequence($urandom_range(1, 2));
    end
    wait_results_drained();
    send_full_window_sequence();
    run_random_phase();
    wait_results_drained();

    repeat (2 * MAP_DEPTH + 16) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
